/* sv/power_button_sequencer_with_leds_assert.svh */
// Assertion macros shared by the power button sequencer RTL.
`ifndef POWER_BUTTON_SEQUENCER_WITH_LEDS_ASSERT_SVH
`define POWER_BUTTON_SEQUENCER_WITH_LEDS_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked property that is ignored while reset is high.
`define PBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds during reset.
`define PBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBS_ASSERT(lbl, clk, rst, prop, msg)
`define PBS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/pbs_pkg.sv */
// Types and constants of the power button sequencer.
`timescale 1ns / 1ps

package pbs_pkg;

   localparam int LIMIT_W = 4;
   localparam int HOLD_W  = 5;

   localparam logic [LIMIT_W-1:0] ON_HOLD_RESET  = 4'd1;
   localparam logic [LIMIT_W-1:0] OFF_HOLD_RESET = 4'd3;

   // Tick kinds carried in tuser.
   localparam logic OP_POWER = 1'b0;
   localparam logic OP_LED   = 1'b1;

   // Configuration register indexes.
   localparam logic REG_ON_HOLD  = 1'b0;
   localparam logic REG_OFF_HOLD = 1'b1;

   // LED levels {local, link, wifi} while power is not on.
   localparam logic [2:0] LEDS_DARK = 3'b100;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_PRON  = 3'd1,
      MODE_ON    = 3'd2,
      MODE_GAP   = 3'd3,
      MODE_PROFF = 3'd4,
      MODE_OFF   = 3'd5
   } mode_type;

   typedef struct packed {
      logic step;
      logic pressed;
   } fsm_ctl_type;

   typedef struct packed {
      mode_type mode_cur;
      mode_type mode_in;
      logic     enable_in;
   } fsm_status_type;

endpackage

/* sv/power_button_sequencer_with_leds.sv */
// Top level of the push-button power sequencer with status LEDs.
`timescale 1ns / 1ps
`include "power_button_sequencer_with_leds_assert.svh"

// Push-button power sequencer with three status LEDs. Each transaction on the
// req_ channel is one tick: a power poll (tuser 0) samples the button level,
// an LED tick (tuser 1) samples the wifi and tcp link flags. Every tick yields
// exactly one rsp_ transaction carrying the power enable, the three LED levels
// and the power state after that tick. The block takes one transaction per
// clock cycle while rsp_tready does not hold it back; each tick passes through
// the input register and then the result register, with the state update done
// as it moves from one to the other. Hold limits are to be written through the
// csr_ port only while no tick is in flight; the block does not enforce this.
module power_button_sequencer_with_leds (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [0] button_level, [1] wifi_linked, [2] tcp_linked, [7:3] zero
   input  logic [7:0]                   req_tdata,
   // [0] opcode
   input  logic [0:0]                   req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [0] power_enable, [1] wifi_led, [2] link_led, [3] board_led,
   // [6:4] power_state, [7] zero
   output logic [7:0]                   rsp_tdata,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [pbs_pkg::LIMIT_W-1:0]  csr_wdata
);
   import pbs_pkg::*;

   logic [LIMIT_W-1:0] on_hold_limit_ff, off_hold_limit_ff;

   logic in_valid_ff;
   logic in_op_ff, in_button_ff, in_wifi_ff, in_tcp_ff;

   logic rsp_valid_ff;
   logic [7:0] rsp_data_ff;

   logic blink_ff, blink_in;
   logic wifi_led_ff, wifi_led_in;
   logic link_led_ff, link_led_in;
   logic board_led_ff, board_led_in;

   logic advance, process, accept;

   fsm_ctl_type    fsm_ctl;
   fsm_status_type fsm_status;

   // The input register moves on whenever the result register is free or drained.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign process    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_hold_limit_ff  <= ON_HOLD_RESET;
         off_hold_limit_ff <= OFF_HOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ON_HOLD:  on_hold_limit_ff  <= csr_wdata;
            REG_OFF_HOLD: off_hold_limit_ff <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff     <= req_tuser[0];
         in_button_ff <= req_tdata[0];
         in_wifi_ff   <= req_tdata[1];
         in_tcp_ff    <= req_tdata[2];
      end
   end

   assign fsm_ctl.step    = process && (in_op_ff == OP_POWER);
   assign fsm_ctl.pressed = in_button_ff;

   pbs_power_fsm u_power_fsm (
      .clock          (clock),
      .reset          (reset),
      .ctl            (fsm_ctl),
      .on_hold_limit  (on_hold_limit_ff),
      .off_hold_limit (off_hold_limit_ff),
      .status         (fsm_status)
   );

   // LED ticks see the power state as it stands; they never change it.
   always_comb begin
      blink_in     = blink_ff;
      wifi_led_in  = wifi_led_ff;
      link_led_in  = link_led_ff;
      board_led_in = board_led_ff;
      if (process && (in_op_ff == OP_LED)) begin
         case (fsm_status.mode_cur) inside
            MODE_ON, MODE_GAP, MODE_PROFF: begin
               wifi_led_in  = in_wifi_ff | blink_ff;
               link_led_in  = in_tcp_ff | ~blink_ff;
               board_led_in = blink_ff;
            end
            default: begin
               {board_led_in, link_led_in, wifi_led_in} = LEDS_DARK;
            end
         endcase
         blink_in = ~blink_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_ff     <= 1'b0;
         wifi_led_ff  <= LEDS_DARK[0];
         link_led_ff  <= LEDS_DARK[1];
         board_led_ff <= LEDS_DARK[2];
      end else begin
         blink_ff     <= blink_in;
         wifi_led_ff  <= wifi_led_in;
         link_led_ff  <= link_led_in;
         board_led_ff <= board_led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= process;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_data_ff <= {1'b0, fsm_status.mode_in, board_led_in, link_led_in,
                         wifi_led_in, fsm_status.enable_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `PBS_ASSERT(a_input_held_on_stall, clock, reset,
      (in_valid_ff && !advance) |=> in_valid_ff,
      "pending transaction dropped while the result side stalls")
   `PBS_ASSERT(a_blink_toggles, clock, reset,
      (process && in_op_ff == OP_LED) |=> (blink_ff != $past(blink_ff)),
      "blink flag did not toggle on an LED tick")
   `PBS_ASSERT(a_power_tick_keeps_blink, clock, reset,
      (process && in_op_ff == OP_POWER) |=> $stable(blink_ff),
      "power tick changed the blink flag")
   `PBS_ASSERT(a_dark_leds_when_off, clock, reset,
      (process && in_op_ff == OP_LED && (fsm_status.mode_cur == MODE_IDLE ||
       fsm_status.mode_cur == MODE_PRON || fsm_status.mode_cur == MODE_OFF))
       |=> (rsp_data_ff[3:1] == LEDS_DARK),
      "LEDs not dark outside the on states")

endmodule

/* sv/pbs_power_fsm.sv */
// Power sequencing state machine with hold counter and enable latch.
`timescale 1ns / 1ps
`include "power_button_sequencer_with_leds_assert.svh"

module pbs_power_fsm (
   input  logic                         clock,
   input  logic                         reset,
   input  pbs_pkg::fsm_ctl_type         ctl,
   input  logic [pbs_pkg::LIMIT_W-1:0]  on_hold_limit,
   input  logic [pbs_pkg::LIMIT_W-1:0]  off_hold_limit,
   output pbs_pkg::fsm_status_type      status
);
   import pbs_pkg::*;

   mode_type          mode_ff, mode_in;
   logic [HOLD_W-1:0] hold_count_ff, hold_count_in;
   logic              enable_ff, enable_in;
   logic              on_more, off_more;

   // The button must stay down past the limit before the state moves on.
   assign on_more  = hold_count_ff <= {1'b0, on_hold_limit};
   assign off_more = hold_count_ff <= {1'b0, off_hold_limit};

   always_comb begin
      mode_in = mode_ff;
      if (ctl.step) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (ctl.pressed) mode_in = MODE_PRON;
            end
            MODE_PRON: begin
               if (!ctl.pressed) mode_in = MODE_IDLE;
               else if (!on_more) mode_in = MODE_ON;
            end
            MODE_ON: begin
               if (!ctl.pressed) mode_in = MODE_GAP;
            end
            MODE_GAP: begin
               if (ctl.pressed) mode_in = MODE_PROFF;
            end
            MODE_PROFF: begin
               if (!ctl.pressed) mode_in = MODE_GAP;
               else if (!off_more) mode_in = MODE_OFF;
            end
            MODE_OFF: begin
               mode_in = MODE_OFF;
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      hold_count_in = hold_count_ff;
      enable_in     = enable_ff;
      if (ctl.step) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               hold_count_in = ctl.pressed ? HOLD_W'(1) : '0;
            end
            MODE_PRON: begin
               if (ctl.pressed && on_more) begin
                  hold_count_in = hold_count_ff + HOLD_W'(1);
               end else begin
                  hold_count_in = '0;
               end
               if (ctl.pressed && !on_more) enable_in = 1'b1;
            end
            MODE_ON, MODE_GAP: begin
               hold_count_in = '0;
            end
            MODE_PROFF: begin
               if (ctl.pressed && off_more) begin
                  hold_count_in = hold_count_ff + HOLD_W'(1);
               end else begin
                  hold_count_in = '0;
               end
               if (ctl.pressed && !off_more) enable_in = 1'b0;
            end
            MODE_OFF: begin
               hold_count_in = '0;
               enable_in     = 1'b0;
            end
            default: begin
               hold_count_in = '0;
               enable_in     = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         hold_count_ff <= '0;
         enable_ff     <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         hold_count_ff <= hold_count_in;
         enable_ff     <= enable_in;
      end
   end

   assign status.mode_cur  = mode_ff;
   assign status.mode_in   = mode_in;
   assign status.enable_in = enable_in;

   `PBS_ASSERT(a_enable_only_when_on, clock, reset, enable_ff |-> (mode_ff == MODE_ON || mode_ff == MODE_GAP || mode_ff == MODE_PROFF), "power enable high outside the on states")
   `PBS_ASSERT(a_off_is_dark, clock, reset, (mode_ff == MODE_OFF) |-> !enable_ff, "power enable high in off state")
   `PBS_ASSERT(a_hold_only_pressing, clock, reset, (hold_count_ff != '0) |-> (mode_ff == MODE_PRON || mode_ff == MODE_PROFF), "hold count nonzero outside a pressing state")

endmodule
